// File: hdl/radio_config_stage_commit_revert_unit_macros.svh
// assertion macros shared by the checker of the settings guard
// no dependencies; included by the files that assert
`ifndef RADIO_CONFIG_STAGE_COMMIT_REVERT_UNIT_MACROS_SVH
`define RADIO_CONFIG_STAGE_COMMIT_REVERT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RCSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("settings guard check failed");

// next-cycle implication, disabled during reset
`define RCSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("settings guard check failed");

`endif

// File: hdl/rcsc_pkg.sv
// types, codes and constants of the radio settings guard
// no dependencies; used by every other file but the macros header
`default_nettype none

package rcsc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COMMIT  = 2'd1,
		PH_RECEIVE = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_REQ    = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_NOTICE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_BUSY   = 2'd2;

	localparam logic [1:0] BW_125K = 2'd0;
	localparam logic [1:0] BW_250K = 2'd1;
	localparam logic [1:0] BW_500K = 2'd2;

	localparam logic [31:0] FREQ_MIN_HZ = 32'd860000000;
	localparam logic [31:0] FREQ_MAX_HZ = 32'd928000000;
	localparam logic signed [7:0] POWER_MAX_DBM = 8'sd22;
	localparam logic [3:0] SF_MIN = 4'd7;
	localparam logic [3:0] SF_MAX = 4'd12;
	localparam logic [7:0] CR_MIN = 8'd1;
	localparam logic [7:0] CR_MAX = 8'd4;

	localparam logic [18:0] BW_HZ_125K = 19'd125000;
	localparam logic [18:0] BW_HZ_250K = 19'd250000;
	localparam logic [18:0] BW_HZ_500K = 19'd500000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [31:0]       now_seconds;
		logic [7:0]        req_id;
		logic [31:0]       req_frequency_hz;
		logic [7:0]        req_spread_factor;
		logic [7:0]        req_bw_code;
		logic [7:0]        req_coding_rate;
		logic signed [7:0] req_power_dbm;
		logic [15:0]       req_preamble_len;
		logic [1:0]        req_flags;
		logic [31:0]       req_commit_time;
		logic [15:0]       req_revert_seconds;
	} req_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              changed;
		logic [7:0]        active_id;
		logic [29:0]       active_frequency_hz;
		logic [3:0]        active_spread_factor;
		logic [18:0]       active_bw_hz;
		logic [2:0]        active_coding_rate;
		logic signed [7:0] active_power_dbm;
		logic [15:0]       active_preamble_len;
		logic [1:0]        active_flags;
		logic [1:0]        slot_phase;
	} rsp_item_t;

	// stored radio settings, narrowed to what a checked request can hold
	typedef struct packed {
		logic [7:0]        id;
		logic [29:0]       freq;
		logic [3:0]        sf;
		logic [1:0]        bw;
		logic [2:0]        cr;
		logic signed [7:0] power;
	} radio_set_t;

	typedef struct packed {
		logic [15:0] preamble;
		logic [1:0]  flags;
		logic [15:0] revert_s;
	} link_set_t;

	// checked request as handed from the check unit to the core
	typedef struct packed {
		logic        pass;
		radio_set_t  radio;
		link_set_t   link;
		logic [31:0] commit_time;
	} chk_t;

	localparam radio_set_t BOOT_RADIO = '{
		id: 8'd1, freq: 30'd868000000, sf: 4'd10, bw: BW_125K, cr: 3'd1,
		power: 8'sd18
	};
	localparam link_set_t BOOT_LINK = '{preamble: 16'd64, flags: 2'd1, revert_s: 16'd0};

	function automatic logic [18:0] bw_hz(input logic [1:0] code);
		logic [18:0] hz;
		case (code)
			BW_250K: hz = BW_HZ_250K;
			BW_500K: hz = BW_HZ_500K;
			default: hz = BW_HZ_125K;
		endcase
		return hz;
	endfunction

endpackage

`default_nettype wire

// File: hdl/rcsc_req_if.sv
// request channel of the settings guard: valid, ready and one input item
// depends on rcsc_pkg
`default_nettype none

interface rcsc_req_if;
	import rcsc_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/rcsc_rsp_if.sv
// result channel of the settings guard: valid, ready and one result item
// depends on rcsc_pkg
`default_nettype none

interface rcsc_rsp_if;
	import rcsc_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/rcsc_check.sv
// range check of a settings request and narrowing into stored form
// depends on rcsc_pkg
`default_nettype none

module rcsc_check (
	input  rcsc_pkg::req_item_t req,
	output rcsc_pkg::chk_t      chk
);
	import rcsc_pkg::*;

	logic freq_ok;
	logic pwr_ok;
	logic sf_ok;
	logic bw_ok;
	logic cr_ok;

	assign freq_ok = (req.req_frequency_hz >= FREQ_MIN_HZ) && (req.req_frequency_hz <= FREQ_MAX_HZ);
	assign pwr_ok  = req.req_power_dbm <= POWER_MAX_DBM;
	assign sf_ok   = (req.req_spread_factor >= {4'd0, SF_MIN})
		&& (req.req_spread_factor <= {4'd0, SF_MAX});
	assign bw_ok   = req.req_bw_code <= {6'd0, BW_500K};
	assign cr_ok   = (req.req_coding_rate >= CR_MIN) && (req.req_coding_rate <= CR_MAX);

	always_comb begin
		chk.pass             = freq_ok && pwr_ok && sf_ok && bw_ok && cr_ok;
		chk.radio.id         = req.req_id;
		chk.radio.freq       = req.req_frequency_hz[29:0];
		chk.radio.sf         = req.req_spread_factor[3:0];
		chk.radio.bw         = req.req_bw_code[1:0];
		chk.radio.cr         = req.req_coding_rate[2:0];
		chk.radio.power      = req.req_power_dbm;
		chk.link.preamble    = req.req_preamble_len;
		chk.link.flags       = req.req_flags;
		chk.link.revert_s    = req.req_revert_seconds;
		chk.commit_time      = req.req_commit_time;
	end
endmodule

`default_nettype wire

// File: hdl/rcsc_core.sv
// settings state: live, fallback and staged sets, phase and revert deadline
// depends on rcsc_pkg; updated once per item, result formed from the new state
`default_nettype none

module rcsc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          kind,
	input  logic [31:0]         now_seconds,
	input  rcsc_pkg::chk_t      chk,
	output rcsc_pkg::rsp_item_t rsp
);
	import rcsc_pkg::*;

	phase_t      phase_q;
	phase_t      phase_d;
	radio_set_t  live_radio_q;
	radio_set_t  live_radio_d;
	link_set_t   live_link_q;
	link_set_t   live_link_d;
	radio_set_t  fb_radio_q;
	radio_set_t  fb_radio_d;
	link_set_t   fb_link_q;
	link_set_t   fb_link_d;
	radio_set_t  stg_radio_q;
	link_set_t   stg_link_q;
	logic [31:0] stg_commit_q;
	logic [31:0] deadline_q;
	logic [31:0] deadline_sum;
	logic        stage_en;
	logic        arm_en;
	logic [1:0]  status;
	logic        changed;

	assign deadline_sum = now_seconds + {16'd0, stg_link_q.revert_s};

	always_comb begin
		phase_d      = phase_q;
		live_radio_d = live_radio_q;
		live_link_d  = live_link_q;
		fb_radio_d   = fb_radio_q;
		fb_link_d    = fb_link_q;
		stage_en     = 1'b0;
		arm_en       = 1'b0;
		status       = ST_OK;
		changed      = 1'b0;
		case (kind)
			KIND_REQ: begin
				if (!chk.pass) begin
					status = ST_REJECT;
				end else if (phase_q != PH_IDLE) begin
					status = ST_BUSY;
				end else begin
					stage_en = 1'b1;
					phase_d  = PH_COMMIT;
				end
			end
			KIND_TICK: begin
				if (phase_q == PH_COMMIT) begin
					if (stg_commit_q == 32'd0 || now_seconds >= stg_commit_q) begin
						fb_radio_d   = live_radio_q;
						fb_link_d    = live_link_q;
						live_radio_d = stg_radio_q;
						live_link_d  = stg_link_q;
						changed      = 1'b1;
						if (stg_link_q.revert_s != 16'd0) begin
							arm_en  = 1'b1;
							phase_d = PH_RECEIVE;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end else if (phase_q == PH_RECEIVE) begin
					if (now_seconds >= deadline_q) begin
						live_radio_d = fb_radio_q;
						live_link_d  = fb_link_q;
						fb_radio_d   = live_radio_q;
						fb_link_d    = live_link_q;
						phase_d      = PH_IDLE;
						changed      = 1'b1;
					end
				end
			end
			KIND_NOTICE: begin
				if (phase_q == PH_RECEIVE) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			live_radio_q <= BOOT_RADIO;
			live_link_q  <= BOOT_LINK;
			fb_radio_q   <= BOOT_RADIO;
			fb_link_q    <= BOOT_LINK;
		end else if (fire) begin
			phase_q      <= phase_d;
			live_radio_q <= live_radio_d;
			live_link_q  <= live_link_d;
			fb_radio_q   <= fb_radio_d;
			fb_link_q    <= fb_link_d;
		end
	end

	// staged set and deadline are read only in the phases that follow their writes
	always_ff @(posedge clk) begin
		if (fire && stage_en) begin
			stg_radio_q  <= chk.radio;
			stg_link_q   <= chk.link;
			stg_commit_q <= chk.commit_time;
		end
		if (fire && arm_en) begin
			deadline_q <= deadline_sum;
		end
	end

	always_comb begin
		rsp.status               = status;
		rsp.changed              = changed;
		rsp.active_id            = live_radio_d.id;
		rsp.active_frequency_hz  = live_radio_d.freq;
		rsp.active_spread_factor = live_radio_d.sf;
		rsp.active_bw_hz         = bw_hz(live_radio_d.bw);
		rsp.active_coding_rate   = live_radio_d.cr;
		rsp.active_power_dbm     = live_radio_d.power;
		rsp.active_preamble_len  = live_link_d.preamble;
		rsp.active_flags         = live_link_d.flags;
		rsp.slot_phase           = phase_d;
	end
endmodule

`default_nettype wire

// File: hdl/radio_config_stage_commit_revert_unit.sv
// top level of the radio settings guard: input register, check, state core, result register
// depends on rcsc_pkg, rcsc_req_if, rcsc_rsp_if, rcsc_check, rcsc_core
//
// usage
//  - item channel: one request per handshake; kind selects a settings request,
//    a time tick carrying now_seconds, or a valid receive notice
//  - result channel: exactly one result per request, in order, carrying the
//    status, whether this tick committed or reverted, the live settings after
//    the update and the slot phase
//  - path: a request is taken into the input register, then handed on to the
//    result register with result.valid high, two register stages from item to result
//  - throughput: one request per cycle sustained while results are taken; the
//    state core logic is combinational (compares, one 32-bit add for the deadline, muxes)
//  - stall: while the result sits unaccepted the input register still fills,
//    so one more request is taken; after that item.ready drops until the
//    result is taken
//  - reset: live and fallback sets load the boot defaults (868 MHz, SF 10,
//    125 kHz, CR 1, 18 dBm, preamble 64, crc on), the slot goes idle and both
//    stages empty; no clearing pass, ready right after reset
`default_nettype none

module radio_config_stage_commit_revert_unit (
	input  logic       clk,
	input  logic       arst_n,
	rcsc_req_if.sink   item,
	rcsc_rsp_if.source result
);
	import rcsc_pkg::*;

	// input stage
	logic      vld_s1;
	req_item_t item_s1;

	// result stage
	logic      vld_s2;
	rsp_item_t rsp_s2;

	logic      adv;
	logic      fire;
	chk_t      chk;
	rsp_item_t rsp_new;

	// the stage-1 request moves on when the result register is free or emptying
	assign adv        = !vld_s2 || result.ready;
	assign fire       = vld_s1 && adv;
	assign item.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
		if (fire) begin
			rsp_s2 <= rsp_new;
		end
	end

	rcsc_check u_check (
		.req (item_s1),
		.chk (chk)
	);

	// state updates only when the request is handed to the result register
	rcsc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.kind        (item_s1.kind),
		.now_seconds (item_s1.now_seconds),
		.chk         (chk),
		.rsp         (rsp_new)
	);

	assign result.valid   = vld_s2;
	assign result.payload = rsp_s2;
endmodule

`default_nettype wire

// File: hdl/rcsc_checker.sv
// port-level checks of the settings guard result channel, bound to the top level
// depends on rcsc_pkg and radio_config_stage_commit_revert_unit_macros.svh
`default_nettype none
`include "radio_config_stage_commit_revert_unit_macros.svh"

module rcsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input rcsc_pkg::rsp_item_t rsp
);
	import rcsc_pkg::*;

	logic busy_rsp;
	logic sf_live_ok;

	assign busy_rsp   = rsp_valid && (rsp.status == ST_BUSY);
	assign sf_live_ok = (rsp.active_spread_factor >= SF_MIN)
		&& (rsp.active_spread_factor <= SF_MAX);

	// a stalled result stays offered
	`RCSC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// a stalled result keeps its contents
	`RCSC_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp))

	// busy means the slot was not idle, and a busy request leaves it so
	`RCSC_ASSERT_NOW(a_busy_phase, clk, arst_n, busy_rsp, rsp.slot_phase != PH_IDLE)

	// only checked settings ever go live; this checks the spread factor range
	`RCSC_ASSERT_NOW(a_sf_range, clk, arst_n, rsp_valid, sf_live_ok)
endmodule

bind radio_config_stage_commit_revert_unit rcsc_checker u_rcsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (result.valid),
	.rsp_ready (result.ready),
	.rsp       (result.payload)
);

`default_nettype wire
